FILE: rtl/ltps_pkg.sv
// Shared types and constants for the line-trace PID steering block.
// No dependencies; every other rtl file refers to this package by scoped names.
package ltps_pkg;

  // Width of the running error-pair sum (trapezoidal integral state)
  localparam int SUM_WIDTH  = 24;
  localparam int ERR_WIDTH  = 8;
  localparam int DIFF_WIDTH = 9;
  localparam int GAIN_WIDTH = 16;

  localparam int P_PROD_WIDTH = GAIN_WIDTH + ERR_WIDTH;
  localparam int I_PROD_WIDTH = GAIN_WIDTH + SUM_WIDTH;
  localparam int D_PROD_WIDTH = GAIN_WIDTH + DIFF_WIDTH;
  localparam int PID_WIDTH    = SUM_WIDTH + GAIN_WIDTH + 2;

  // Q8.8 clamp of the PID sum and integer saturation of the drives
  localparam int PID_LIMIT   = 100 * 256;
  localparam int DRIVE_LIMIT = 100;

  // Register map, index = paddr[ADDR_WIDTH-1:2]
  localparam int ADDR_WIDTH = 5;
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_BASE   = 3'd4;

  localparam logic [6:0]  TARGET_RESET = 7'd50;
  localparam logic [15:0] GAIN_P_RESET = 16'd256;

  typedef struct packed {
    logic [6:0]         target_brightness;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i_half_dt;
    logic signed [15:0] gain_d_over_dt;
    logic signed [7:0]  base_speed;
  } cfg_t;

endpackage

FILE: rtl/ltps_regs.sv
// APB-style configuration register file for the steering block.
// Depends on ltps_pkg (register map, reset values, cfg_t).
module ltps_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltps_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ltps_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[ltps_pkg::ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_brightness <= ltps_pkg::TARGET_RESET;
      cfg.gain_p            <= ltps_pkg::GAIN_P_RESET;
      cfg.gain_i_half_dt    <= '0;
      cfg.gain_d_over_dt    <= '0;
      cfg.base_speed        <= '0;
    end else if (wr_en) begin
      unique case (index)
        ltps_pkg::REG_TARGET: cfg.target_brightness <= pwdata[6:0];
        ltps_pkg::REG_GAIN_P: cfg.gain_p            <= pwdata[15:0];
        ltps_pkg::REG_GAIN_I: cfg.gain_i_half_dt    <= pwdata[15:0];
        ltps_pkg::REG_GAIN_D: cfg.gain_d_over_dt    <= pwdata[15:0];
        ltps_pkg::REG_BASE:   cfg.base_speed        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      ltps_pkg::REG_TARGET: prdata = {25'd0, cfg.target_brightness};
      ltps_pkg::REG_GAIN_P: prdata = {{16{cfg.gain_p[15]}}, cfg.gain_p};
      ltps_pkg::REG_GAIN_I: prdata = {{16{cfg.gain_i_half_dt[15]}}, cfg.gain_i_half_dt};
      ltps_pkg::REG_GAIN_D: prdata = {{16{cfg.gain_d_over_dt[15]}}, cfg.gain_d_over_dt};
      ltps_pkg::REG_BASE:   prdata = {{24{cfg.base_speed[7]}}, cfg.base_speed};
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ltps_error.sv
// Brightness, error, error difference and saturating pair-sum integral.
// Holds the block's state (previous error, pair sum). Depends on ltps_pkg.
module ltps_error (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  ld,
  input  logic [7:0]                            red,
  input  logic [7:0]                            green,
  input  logic [7:0]                            blue,
  input  logic [6:0]                            target,
  output logic signed [ltps_pkg::ERR_WIDTH-1:0] err,
  output logic signed [ltps_pkg::SUM_WIDTH-1:0] pair_sum,
  output logic signed [ltps_pkg::DIFF_WIDTH-1:0] diff
);

  localparam int SW = ltps_pkg::SUM_WIDTH;

  logic [7:0]          mx;
  logic [14:0]         scaled;
  logic [15:0]         recip;
  logic [6:0]          bright;
  logic signed [7:0]   err_next;
  logic signed [8:0]   pair;
  logic signed [SW:0]  sum_wide;
  logic signed [SW-1:0] sum_next;
  logic signed [8:0]   diff_next;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
  end

  // floor(x/255) = (x + (x>>8) + 1) >> 8, exact for x below 65280
  assign scaled   = 15'(mx) * 15'd100;
  assign recip    = {1'b0, scaled} + {9'd0, scaled[14:8]} + 16'd1;
  assign bright   = recip[14:8];
  assign err_next = $signed({1'b0, bright}) - $signed({1'b0, target});

  assign pair      = {err_next[7], err_next} + {err[7], err};
  assign diff_next = {err_next[7], err_next} - {err[7], err};
  assign sum_wide  = {pair_sum[SW-1], pair_sum} + {{(SW+1-9){pair[8]}}, pair};

  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_next = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SW-1:0];
    end
  end

  // err holds the previous error once the item has passed
  always_ff @(posedge clk) begin
    if (rst) begin
      err      <= '0;
      pair_sum <= '0;
    end else if (ld) begin
      err      <= err_next;
      pair_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      diff <= diff_next;
    end
  end

endmodule

FILE: rtl/ltps_mult.sv
// Registered P, I and D products of the gains with error terms.
// Depends on ltps_pkg (widths, cfg_t).
module ltps_mult (
  input  logic                                     clk,
  input  logic                                     ld,
  input  ltps_pkg::cfg_t                           cfg,
  input  logic signed [ltps_pkg::ERR_WIDTH-1:0]    err,
  input  logic signed [ltps_pkg::SUM_WIDTH-1:0]    pair_sum,
  input  logic signed [ltps_pkg::DIFF_WIDTH-1:0]   diff,
  output logic signed [ltps_pkg::P_PROD_WIDTH-1:0] p_prod,
  output logic signed [ltps_pkg::I_PROD_WIDTH-1:0] i_prod,
  output logic signed [ltps_pkg::D_PROD_WIDTH-1:0] d_prod
);

  localparam int PPW = ltps_pkg::P_PROD_WIDTH;
  localparam int IPW = ltps_pkg::I_PROD_WIDTH;
  localparam int DPW = ltps_pkg::D_PROD_WIDTH;

  always_ff @(posedge clk) begin
    if (ld) begin
      p_prod <= PPW'($signed(cfg.gain_p)) * PPW'($signed(err));
      i_prod <= IPW'($signed(cfg.gain_i_half_dt)) * IPW'($signed(pair_sum));
      d_prod <= DPW'($signed(cfg.gain_d_over_dt)) * DPW'($signed(diff));
    end
  end

endmodule

FILE: rtl/ltps_drive.sv
// PID sum, Q8.8 clamp, truncation toward zero and saturated wheel drives.
// Depends on ltps_pkg (widths, limits, cfg_t).
module ltps_drive (
  input  logic                                     clk,
  input  logic                                     ld,
  input  ltps_pkg::cfg_t                           cfg,
  input  logic signed [ltps_pkg::P_PROD_WIDTH-1:0] p_prod,
  input  logic signed [ltps_pkg::I_PROD_WIDTH-1:0] i_prod,
  input  logic signed [ltps_pkg::D_PROD_WIDTH-1:0] d_prod,
  output logic signed [7:0]                        turn_amount,
  output logic signed [7:0]                        left_drive,
  output logic signed [7:0]                        right_drive
);

  localparam int PW = ltps_pkg::PID_WIDTH;
  localparam logic signed [PW-1:0] PID_HI = PW'(ltps_pkg::PID_LIMIT);
  localparam logic signed [PW-1:0] PID_LO = -PID_HI;
  localparam logic signed [8:0]    DRV_HI = 9'(ltps_pkg::DRIVE_LIMIT);
  localparam logic signed [8:0]    DRV_LO = -DRV_HI;

  logic signed [PW-1:0] pid;
  logic signed [15:0]   pid_c;
  logic signed [7:0]    turn;
  logic signed [8:0]    left_w;
  logic signed [8:0]    right_w;
  logic signed [7:0]    left_s;
  logic signed [7:0]    right_s;

  assign pid = PW'($signed(p_prod)) + PW'($signed(i_prod)) + PW'($signed(d_prod));

  always_comb begin
    if (pid > PID_HI) begin
      pid_c = PID_HI[15:0];
    end else if (pid < PID_LO) begin
      pid_c = PID_LO[15:0];
    end else begin
      pid_c = pid[15:0];
    end
  end

  // floor by shift, then step up for a negative value with a fraction
  assign turn = pid_c[15:8] + {7'd0, pid_c[15] && (pid_c[7:0] != 8'd0)};

  assign left_w  = {cfg.base_speed[7], cfg.base_speed} - {turn[7], turn};
  assign right_w = {cfg.base_speed[7], cfg.base_speed} + {turn[7], turn};

  always_comb begin
    if (left_w > DRV_HI)      left_s = DRV_HI[7:0];
    else if (left_w < DRV_LO) left_s = DRV_LO[7:0];
    else                      left_s = left_w[7:0];
    if (right_w > DRV_HI)      right_s = DRV_HI[7:0];
    else if (right_w < DRV_LO) right_s = DRV_LO[7:0];
    else                       right_s = right_w[7:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      turn_amount <= turn;
      left_drive  <= left_s;
      right_drive <= right_s;
    end
  end

endmodule

FILE: rtl/line_trace_pid_steering.sv
// Line-trace PID steering: one RGB sample in, turn value and two wheel drives out.
// Four register stages: sample, error/integral, products, result. One transfer per
// cycle is sustained while out_ready keeps the result register draining, as the
// pair-sum update closes within the error stage. Synchronous reset clears the
// pipeline, the previous error and the pair sum, and loads register defaults.
module line_trace_pid_steering (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [7:0]             turn_amount,
  output logic signed [7:0]             left_drive,
  output logic signed [7:0]             right_drive,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltps_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ltps_pkg::cfg_t cfg;

  // Stage valids; each stage loads when it is empty or its contents move on
  logic s1_valid, s2_valid, s3_valid;
  logic s1_free, s2_free, s3_free, out_free;
  logic s2_ld, s3_ld, out_ld;

  // Sample register
  logic [7:0] s1_red, s1_green, s1_blue;

  logic signed [ltps_pkg::ERR_WIDTH-1:0]    err;
  logic signed [ltps_pkg::SUM_WIDTH-1:0]    pair_sum;
  logic signed [ltps_pkg::DIFF_WIDTH-1:0]   diff;
  logic signed [ltps_pkg::P_PROD_WIDTH-1:0] p_prod;
  logic signed [ltps_pkg::I_PROD_WIDTH-1:0] i_prod;
  logic signed [ltps_pkg::D_PROD_WIDTH-1:0] d_prod;

  // Ready ripples back from the result register; a waiting result
  // still lets upstream bubbles fill.
  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  // State advances exactly once per item, when it leaves the sample register
  assign s2_ld  = s2_free && s1_valid;
  assign s3_ld  = s3_free && s2_valid;
  assign out_ld = out_free && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free)  s1_valid  <= in_valid;
      if (s2_free)  s2_valid  <= s1_valid;
      if (s3_free)  s3_valid  <= s2_valid;
      if (out_free) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
    end
  end

  ltps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltps_error u_error (
    .clk      (clk),
    .rst      (rst),
    .ld       (s2_ld),
    .red      (s1_red),
    .green    (s1_green),
    .blue     (s1_blue),
    .target   (cfg.target_brightness),
    .err      (err),
    .pair_sum (pair_sum),
    .diff     (diff)
  );

  ltps_mult u_mult (
    .clk      (clk),
    .ld       (s3_ld),
    .cfg      (cfg),
    .err      (err),
    .pair_sum (pair_sum),
    .diff     (diff),
    .p_prod   (p_prod),
    .i_prod   (i_prod),
    .d_prod   (d_prod)
  );

  ltps_drive u_drive (
    .clk         (clk),
    .ld          (out_ld),
    .cfg         (cfg),
    .p_prod      (p_prod),
    .i_prod      (i_prod),
    .d_prod      (d_prod),
    .turn_amount (turn_amount),
    .left_drive  (left_drive),
    .right_drive (right_drive)
  );

`ifndef SYNTHESIS
  // A transfer always lands in the sample register
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("input transfer lost");

  // Integral state moves only when an item passes the error stage
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    !s2_ld |=> $stable(pair_sum) && $stable(err))
    else $error("pair sum changed without an item");

  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (turn_amount <= 8'sd100) && (turn_amount >= -8'sd100))
    else $error("turn value out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive <= 8'sd100) && (left_drive >= -8'sd100) &&
                  (right_drive <= 8'sd100) && (right_drive >= -8'sd100))
    else $error("drive out of range");
`endif

endmodule

FILE: dv/tb_line_trace_pid_steering.sv
`timescale 1ns / 100ps
// Testbench for line_trace_pid_steering: queued RGB samples, scoreboard of predicted
// turn/drive results, APB register programming between phases. Uses ltps_pkg.
module tb_line_trace_pid_steering;

  // One queued color sample. drain: hold it back until every result is back.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         drain;
  } color_t;

  // Predicted result for one accepted sample
  typedef struct {
    logic signed [7:0] turn;
    logic signed [7:0] left;
    logic signed [7:0] right;
  } steering_t;

  localparam int     SW        = ltps_pkg::SUM_WIDTH;
  localparam int     AW        = ltps_pkg::ADDR_WIDTH;
  localparam longint SUM_MAX   = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SUM_MIN   = -SUM_MAX - 1;
  localparam int     REG_SLOTS = 1 << $bits(ltps_pkg::REG_BASE);
  localparam int     TAIL_CYCLES = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [7:0]     turn_amount;
  logic signed [7:0]     left_drive;
  logic signed [7:0]     right_drive;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AW-1:0]         paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  line_trace_pid_steering DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .turn_amount (turn_amount),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the registers and the controller state, as after reset
  ltps_pkg::cfg_t          shadow_cfg = '{target_brightness: ltps_pkg::TARGET_RESET,
                                          gain_p:            ltps_pkg::GAIN_P_RESET,
                                          gain_i_half_dt:    '0,
                                          gain_d_over_dt:    '0,
                                          base_speed:        '0};
  logic signed [7:0]    last_error = '0;
  logic signed [SW-1:0] pair_sum = '0;

  color_t    pending_colors[$];
  steering_t expected_steering[$];
  color_t    head_color;
  steering_t want;
  int        error_count = 0;
  // idle odds in percent, changed by the sequencer between phases
  int        send_idle_pct = 19;
  int        recv_idle_pct = 76;

  function automatic int clip_drive(int v);
    if (v > ltps_pkg::DRIVE_LIMIT) return ltps_pkg::DRIVE_LIMIT;
    if (v < -ltps_pkg::DRIVE_LIMIT) return -ltps_pkg::DRIVE_LIMIT;
    return v;
  endfunction

  // Next turn/drive values for one sample; advances the shadow state.
  function automatic steering_t predict_steering(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
    int unsigned peak;
    int          bright;
    int          err;
    int          turn;
    longint      sum;
    longint      pid;
    steering_t   res;
    peak = 32'(r);
    if (g > peak) peak = 32'(g);
    if (b > peak) peak = 32'(b);
    bright = int'((peak * 100) / 255);
    err = bright - int'(shadow_cfg.target_brightness);
    // trapezoidal pair sum, saturating at the state width
    sum = longint'(pair_sum) + longint'(err) + longint'(last_error);
    if (sum > SUM_MAX) sum = SUM_MAX;
    if (sum < SUM_MIN) sum = SUM_MIN;
    pid = longint'(shadow_cfg.gain_p) * longint'(err)
        + longint'(shadow_cfg.gain_i_half_dt) * sum
        + longint'(shadow_cfg.gain_d_over_dt) * (longint'(err) - longint'(last_error));
    // clamp in Q8.8 first, then truncate toward zero
    if (pid > ltps_pkg::PID_LIMIT) pid = ltps_pkg::PID_LIMIT;
    if (pid < -ltps_pkg::PID_LIMIT) pid = -ltps_pkg::PID_LIMIT;
    turn = int'(pid / 256);
    res.turn  = 8'(turn);
    res.left  = 8'(clip_drive(int'(shadow_cfg.base_speed) - turn));
    res.right = 8'(clip_drive(int'(shadow_cfg.base_speed) + turn));
    last_error = 8'(err);
    pair_sum = SW'(sum);
    return res;
  endfunction

  // Driver: present queued samples, predict on every input transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_steering.push_back(predict_steering(red, green, blue));
      end
      // slot is free when nothing is held or the held sample just transferred
      if (!in_valid || in_ready) begin
        if (pending_colors.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending_colors[0].drain || expected_steering.size() == 0)) begin
          head_color = pending_colors.pop_front();
          in_valid <= 1'b1;
          red      <= head_color.red;
          green    <= head_color.green;
          blue     <= head_color.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_steering.size() == 0) begin
        $error("result with nothing expected: turn %0d left %0d right %0d",
               turn_amount, left_drive, right_drive);
        error_count++;
      end else begin
        want = expected_steering.pop_front();
        if (turn_amount !== want.turn) begin
          $error("turn_amount: expected %0d, actual %0d", want.turn, turn_amount);
          error_count++;
        end
        if (left_drive !== want.left) begin
          $error("left_drive: expected %0d, actual %0d", want.left, left_drive);
          error_count++;
        end
        if (right_drive !== want.right) begin
          $error("right_drive: expected %0d, actual %0d", want.right, right_drive);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ltps_pkg::REG_TARGET: shadow_cfg.target_brightness = value[6:0];
      ltps_pkg::REG_GAIN_P: shadow_cfg.gain_p = value[15:0];
      ltps_pkg::REG_GAIN_I: shadow_cfg.gain_i_half_dt = value[15:0];
      ltps_pkg::REG_GAIN_D: shadow_cfg.gain_d_over_dt = value[15:0];
      ltps_pkg::REG_BASE:   shadow_cfg.base_speed = value[7:0];
      default: ;  // unmapped slot, write dropped
    endcase
  endtask

  // Program all five registers; upper data bits carry junk that must be dropped.
  task automatic apply_setting(input ltps_pkg::cfg_t c);
    write_reg(ltps_pkg::REG_TARGET, {25'($urandom), c.target_brightness});
    write_reg(ltps_pkg::REG_GAIN_P, {16'($urandom), c.gain_p});
    write_reg(ltps_pkg::REG_GAIN_I, {16'($urandom), c.gain_i_half_dt});
    write_reg(ltps_pkg::REG_GAIN_D, {16'($urandom), c.gain_d_over_dt});
    write_reg(ltps_pkg::REG_BASE,   {24'($urandom), c.base_speed});
  endtask

  function automatic ltps_pkg::cfg_t make_setting(int t, int p, int i, int d, int b);
    ltps_pkg::cfg_t c;
    c.target_brightness = 7'(t);
    c.gain_p            = 16'(p);
    c.gain_i_half_dt    = 16'(i);
    c.gain_d_over_dt    = 16'(d);
    c.base_speed        = 8'(b);
    return c;
  endfunction

  // Mostly moderate gains so the turn value moves; sometimes full range.
  function automatic ltps_pkg::cfg_t random_setting();
    int full;
    full = $urandom_range(3);
    return make_setting(
      (full == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100),
      (full == 1) ? $urandom : $urandom_range(0, 2048) - 1024,
      (full == 2) ? $urandom : $urandom_range(0, 64) - 32,
      (full == 3) ? $urandom : $urandom_range(0, 2048) - 1024,
      $urandom_range(1) ? $urandom : $urandom_range(0, 200) - 100);
  endfunction

  function automatic logic [7:0] random_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_color(input int r, input int g, input int b, input bit drain = 0);
    color_t c;
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    c.drain = drain;
    pending_colors.push_back(c);
  endtask

  // Random samples; short bursts of one color let the integral build up.
  task automatic push_random_colors(input int count);
    int left_to_go;
    int burst;
    logic [7:0] r, g, b;
    left_to_go = count;
    while (left_to_go > 0) begin
      r = random_channel();
      g = random_channel();
      b = random_channel();
      burst = ($urandom_range(3) == 0) ? $urandom_range(2, 8) : 1;
      repeat (burst) begin
        push_color(r, g, b, $urandom_range(99) == 0);
        left_to_go--;
      end
    end
  endtask

  // Block until every queued sample went in and every result came back.
  // Checked at the falling edge, once the rising-edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_colors.size() != 0 || in_valid || expected_steering.size() != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers: turn equals the error, clipped.
    push_color(0, 0, 0);          // black, most negative error
    push_color(255, 255, 255);    // white, brightness 100
    push_color(255, 0, 0);        // each channel alone at full scale
    push_color(0, 255, 0);
    push_color(0, 0, 255);
    push_color(128, 64, 200);
    push_color(3, 2, 1);          // brightness floors to 1
    push_color(2, 1, 0);          // brightness floors to 0
    wait_idle();

    // Gain and target extremes, base speed beyond the drive range.
    apply_setting(make_setting(127, -32768, 32767, -32768, 127));
    for (int k = ltps_pkg::REG_BASE + 1; k < REG_SLOTS; k++) begin
      write_reg(3'(k), $urandom);  // unmapped slots, must change nothing
    end
    push_color(0, 0, 0);
    push_color(255, 255, 255);
    push_color(0, 0, 0);
    push_color(17, 200, 90);
    wait_idle();

    apply_setting(make_setting(0, 32767, -32768, 32767, -128));
    push_color(255, 255, 255);
    push_color(0, 0, 0);
    push_color(255, 255, 255);
    push_color(90, 17, 200);
    wait_idle();

    // Gain 1.5, error -1: truncation toward zero gives -1, not -2.
    apply_setting(make_setting(100, 384, 0, 0, 0));
    push_color(254, 0, 0);
    push_color(0, 0, 0);
    push_color(0, 253, 0);
    push_color(0, 0, 255);
    wait_idle();

    // Random part: six register settings over the three idle modes.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 19;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(random_setting());
      // first item of the swapped mode waits for the pipeline to run dry
      if (phase == 2) push_color(255, 0, 255, 1);
      push_random_colors(270);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
